@@ hdl/jsg_pkg.sv @@
// Shared types, constants and the log2 step table builder for the jet split groomer selector.
// Used by jsg_front, jsg_back and the top level; depends on nothing else.
package jsg_pkg;

	localparam int MAX_SPLITS_DEF = 64;
	localparam int LOG_DEPTH      = 64;
	localparam int LOG_IDX_W      = $clog2(LOG_DEPTH);

	localparam logic [47:0] KEY_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] KEY_OFFSET = 48'h0100_0000_0000;

	// mode codes
	localparam logic [2:0] MODE_DYN   = 3'd0;
	localparam logic [2:0] MODE_SPT   = 3'd1;
	localparam logic [2:0] MODE_Z     = 3'd2;
	localparam logic [2:0] MODE_KT    = 3'd3;
	localparam logic [2:0] MODE_KAPPA = 3'd4;
	localparam logic [2:0] MODE_ZD2   = 3'd5;
	localparam logic [2:0] MODE_MINZD = 3'd6;
	localparam logic [2:0] MODE_SD    = 3'd7;

	// register indexes
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_ALPHA = 3'd1;
	localparam logic [2:0] REG_BETA  = 3'd2;
	localparam logic [2:0] REG_ZCUT  = 3'd3;
	localparam logic [2:0] REG_R0    = 3'd4;

	typedef struct packed {
		logic [15:0] z;
		logic [15:0] delta;
		logic [23:0] kt;
		logic [23:0] kappa;
		logic [23:0] pair_pt;
		logic [23:0] softer_pt;
		logic        empty_jet;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [5:0] selected_index;
		logic       found;
		logic       overflow;
	} out_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [11:0] alpha;
		logic signed [11:0] beta;
		logic [15:0]        zcut;
		logic [15:0]        r0;
	} cfg_t;

	// scored word handed from front to back
	typedef struct packed {
		logic [47:0] key;
		logic        ok;
		logic        first_pass;
		logic        empty_jet;
		logic        last;
	} mid_t;

	typedef logic [LOG_DEPTH-1:0][15:0] log_tbl_t;

	// log2(1 + idx/LOG_DEPTH) in Q0.16, by repeated exact squaring, truncated
	function automatic logic [15:0] log_step(int unsigned idx);
		logic [63:0] v;
		logic [15:0] r;
		v = ((64'(LOG_DEPTH) + 64'(idx)) << 30) / 64'(LOG_DEPTH);
		r = '0;
		for (int i = 0; i < 16; i++) begin
			v = (v * v) >> 30;
			r = {r[14:0], 1'b0};
			if (v >= 64'h8000_0000) begin
				v = v >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic log_tbl_t build_log_tbl();
		log_tbl_t t;
		for (int i = 0; i < LOG_DEPTH; i++) begin
			t[i] = log_step(i);
		end
		return t;
	endfunction

endpackage

@@ hdl/jsg_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Generic in word type; no package use.
module jsg_fifo #(
	parameter type word_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  word_t wdata,
	input  logic  pop,
	output logic  empty,
	output word_t rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	word_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

@@ hdl/jsg_front.sv @@
// Front end: accepts a split word and forms its score key through a shared log2 unit.
// Depends on jsg_pkg.
module jsg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  jsg_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  jsg_pkg::in_t  in_word,
	output logic          mid_push,
	input  logic          mid_full,
	output jsg_pkg::mid_t mid_word
);
	import jsg_pkg::*;

	localparam log_tbl_t LOG_TBL = build_log_tbl();
	localparam int       MW      = 31 + $clog2(LOG_DEPTH + 1);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_LOG  = 4'b0010,
		F_MUL  = 4'b0100,
		F_FIN  = 4'b1000
	} fstate_t;

	fstate_t            state_q;
	in_t                it_q;
	cfg_t               cfg_q;
	logic [1:0]         slot_q;
	logic               ph_q;
	logic signed [23:0] a_q, b_q;
	logic [31:0]        zd_q;
	logic [47:0]        tf_q;
	logic signed [35:0] prod_q;

	logic [23:0]        x_s1;
	logic [4:0]         e_s1;
	logic [4:0]         fb_s1;
	logic               to_b_s1, neg_s1;

	logic               is_sd;
	logic [15:0]        rr;
	logic [23:0]        op_x;
	logic [4:0]         op_fb;
	logic [4:0]         op_e;
	logic [31:0]        shifted;
	logic [MW-1:0]      idx_full;
	logic [LOG_IDX_W-1:0] idx;
	logic signed [7:0]  ex;
	logic signed [23:0] lgv;

	logic signed [27:0] pow;
	logic signed [28:0] s_sum;
	logic [47:0]        key;
	logic               ok;

	assign is_sd = (cfg_q.mode == MODE_SD);
	assign rr    = (cfg_q.r0 == '0) ? 16'd1 : cfg_q.r0;
	assign full  = (state_q != F_IDLE);

	// operand for the current log slot
	always_comb begin
		op_x  = 24'(it_q.z);
		op_fb = 5'd16;
		case (slot_q)
			2'd0: begin
				op_x  = 24'(it_q.z);
				op_fb = 5'd16;
			end
			2'd1: begin
				op_x  = is_sd ? 24'(cfg_q.zcut) : 24'(17'h10000 - {1'b0, it_q.z});
				op_fb = 5'd16;
			end
			2'd2: begin
				op_x  = is_sd ? 24'(it_q.delta) : it_q.pair_pt;
				op_fb = is_sd ? 5'd14 : 5'd8;
			end
			2'd3: begin
				op_x  = is_sd ? 24'(rr) : 24'(it_q.delta);
				op_fb = 5'd14;
			end
			default: begin
				op_x  = 24'(it_q.z);
				op_fb = 5'd16;
			end
		endcase
	end

	// leading one position
	always_comb begin
		op_e = '0;
		for (int i = 0; i < 24; i++) begin
			if (op_x[i]) begin
				op_e = 5'(i);
			end
		end
	end

	// mantissa index, table lookup, integer part
	always_comb begin
		shifted  = 32'(x_s1) << (5'd31 - e_s1);
		idx_full = (MW'(shifted[30:0]) * MW'(LOG_DEPTH)) >> 31;
		idx      = LOG_IDX_W'(idx_full);
		ex       = $signed({3'b0, e_s1}) - $signed({3'b0, fb_s1});
		lgv      = $signed({ex, 16'b0}) + $signed({8'b0, LOG_TBL[idx]});
	end

	// power term floored, and final key
	always_comb begin
		pow   = prod_q[35:8];
		s_sum = 29'(a_q) + ((it_q.delta != '0) ? 29'(pow) : 29'sd0);
		key   = '0;
		ok    = 1'b0;
		case (cfg_q.mode)
			MODE_DYN: begin
				if (it_q.z == '0 || it_q.pair_pt == '0) begin
					ok = 1'b0;
				end else if (it_q.delta == '0 && cfg_q.alpha > 0) begin
					ok = 1'b0;
				end else if (it_q.delta == '0 && cfg_q.alpha < 0) begin
					key = KEY_MAX;
					ok  = 1'b1;
				end else begin
					key = 48'($signed(s_sum)) + KEY_OFFSET;
					ok  = 1'b1;
				end
			end
			MODE_SPT: begin
				key = 48'(it_q.softer_pt);
				ok  = (it_q.softer_pt != '0);
			end
			MODE_Z: begin
				key = 48'(it_q.z);
				ok  = (it_q.z != '0);
			end
			MODE_KT: begin
				key = 48'(it_q.kt);
				ok  = (it_q.kt != '0);
			end
			MODE_KAPPA: begin
				key = 48'(it_q.kappa);
				ok  = (it_q.kappa != '0);
			end
			MODE_ZD2: begin
				key = tf_q;
				ok  = (tf_q != '0);
			end
			MODE_MINZD: begin
				key = KEY_MAX - tf_q;
				ok  = 1'b1;
			end
			MODE_SD: begin
				if (cfg_q.beta == '0) begin
					ok = (it_q.z > cfg_q.zcut);
				end else if (it_q.z == '0) begin
					ok = 1'b0;
				end else if (cfg_q.zcut == '0) begin
					ok = 1'b1;
				end else if (it_q.delta == '0) begin
					ok = (cfg_q.beta > 0);
				end else begin
					ok = ($signed(29'(a_q)) > $signed(29'(pow)));
				end
			end
			default: begin
				key = '0;
				ok  = 1'b0;
			end
		endcase
	end

	assign mid_push            = (state_q == F_FIN);
	assign mid_word.key        = key;
	assign mid_word.ok         = ok;
	assign mid_word.first_pass = is_sd;
	assign mid_word.empty_jet  = it_q.empty_jet;
	assign mid_word.last       = it_q.last;

	// word capture and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			it_q  <= in_word;
			cfg_q <= cfg;
			a_q   <= '0;
			b_q   <= '0;
		end
		if (state_q == F_LOG && !ph_q) begin
			x_s1    <= op_x;
			e_s1    <= op_e;
			fb_s1   <= op_fb;
			to_b_s1 <= (slot_q == 2'd3) || (is_sd && slot_q == 2'd2);
			neg_s1  <= is_sd && (slot_q == 2'd1 || slot_q == 2'd3);
			if (slot_q == 2'd0) begin
				zd_q <= it_q.z * it_q.delta;
			end
		end
		if (state_q == F_LOG && ph_q) begin
			if (to_b_s1) begin
				b_q <= neg_s1 ? b_q - lgv : b_q + lgv;
			end else begin
				a_q <= neg_s1 ? a_q - lgv : a_q + lgv;
			end
		end
		if (state_q == F_MUL) begin
			prod_q <= (is_sd ? cfg_q.beta : cfg_q.alpha) * b_q;
			tf_q   <= zd_q * it_q.delta;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			slot_q  <= '0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_LOG;
						slot_q  <= '0;
						ph_q    <= 1'b0;
					end
				end
				F_LOG: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						slot_q <= slot_q + 1'b1;
						if (slot_q == 2'd3) begin
							state_q <= F_MUL;
						end
					end
				end
				F_MUL: begin
					state_q <= F_FIN;
				end
				F_FIN: begin
					if (!mid_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hdl/jsg_back.sv @@
// Back end: keeps each jet's best split (SD: first passing); one result per jet.
// Depends on jsg_pkg.
module jsg_back #(
	parameter int MAX_SPLITS = jsg_pkg::MAX_SPLITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mid_empty,
	output logic          mid_pop,
	input  jsg_pkg::mid_t mid_word,
	output logic          res_push,
	input  logic          res_full,
	output jsg_pkg::out_t res_word
);
	import jsg_pkg::*;

	localparam int CW = $clog2(MAX_SPLITS + 1);

	logic [47:0]   best_q;
	logic [5:0]    best_idx_q;
	logic          have_q;
	logic [CW-1:0] cnt_q;
	logic          many_q;

	logic [47:0]   best_n;
	logic [5:0]    best_idx_n;
	logic          have_n;
	logic [CW-1:0] cnt_n;
	logic          many_n;
	logic          take;
	logic          ends;

	assign mid_pop  = !mid_empty && !res_full;
	assign ends     = mid_word.empty_jet || mid_word.last;
	assign res_push = mid_pop && ends;

	// step the jet state for the word at the head
	always_comb begin
		best_n     = best_q;
		best_idx_n = best_idx_q;
		have_n     = have_q;
		cnt_n      = cnt_q;
		many_n     = many_q;
		take       = 1'b0;
		if (!mid_word.empty_jet) begin
			if (cnt_q >= CW'(MAX_SPLITS)) begin
				many_n = 1'b1;
			end else begin
				take = mid_word.first_pass ? (mid_word.ok && !have_q)
				                           : (mid_word.ok && (!have_q || mid_word.key > best_q));
				if (take) begin
					best_n     = mid_word.key;
					best_idx_n = 6'(cnt_q);
					have_n     = 1'b1;
				end
				cnt_n = cnt_q + 1'b1;
			end
		end
		res_word.selected_index = have_n ? best_idx_n : 6'd0;
		res_word.found          = have_n;
		res_word.overflow       = many_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_idx_q <= '0;
			have_q     <= 1'b0;
			cnt_q      <= '0;
			many_q     <= 1'b0;
		end else if (mid_pop) begin
			if (ends) begin
				best_q     <= '0;
				best_idx_q <= '0;
				have_q     <= 1'b0;
				cnt_q      <= '0;
				many_q     <= 1'b0;
			end else begin
				best_q     <= best_n;
				best_idx_q <= best_idx_n;
				have_q     <= have_n;
				cnt_q      <= cnt_n;
				many_q     <= many_n;
			end
		end
	end

	// split count never passes the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SPLITS))
		else $error("split count beyond limit");

	// a result always clears the jet state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (!have_q && cnt_q == '0 && !many_q))
		else $error("jet state not cleared after result");

	// overflow needs a full jet behind it
	a_many: assert property (@(posedge clk) disable iff (!arst_n)
		many_q |-> (cnt_q == CW'(MAX_SPLITS)))
		else $error("overflow without full count");
endmodule

@@ hdl/jet_split_groomer_selector_core.sv @@
// Top level of the jet split groomer selector: configuration registers, front, queues, back.
// Depends on jsg_pkg, jsg_fifo, jsg_front and jsg_back.
//
// Feed the primary declusterings of a jet one word at a time, last marked; one result word
// per jet gives the chosen split's index, a found flag and an overflow flag. Each input word
// occupies the front through an accept step, four base-2 logarithms through the single
// shared log unit, each an operand phase then an accumulate phase, a multiply step and an issue
// step that waits on a full middle queue. Two-word queues sit between front and back and at
// the result port; full queues stall input. Registers sit on an APB port at byte address 4*i
// (mode, alpha, beta, zcut, r0) and should be written only while the block is idle.
module jet_split_groomer_selector_core #(
	parameter int MAX_SPLITS = jsg_pkg::MAX_SPLITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          push,
	output logic          full,
	input  jsg_pkg::in_t  in_word,
	output logic          empty,
	input  logic          pop,
	output jsg_pkg::out_t result
);
	import jsg_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       mid_push, mid_full, mid_empty, mid_pop;
	mid_t       mid_in, mid_out;
	logic       res_push, res_full;
	out_t       res_word;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_SD;
			cfg_q.alpha <= 12'sd256;
			cfg_q.beta  <= 12'sd0;
			cfg_q.zcut  <= 16'd6554;
			cfg_q.r0    <= 16'd6554;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:  cfg_q.mode  <= pwdata[2:0];
				REG_ALPHA: cfg_q.alpha <= pwdata[11:0];
				REG_BETA:  cfg_q.beta  <= pwdata[11:0];
				REG_ZCUT:  cfg_q.zcut  <= pwdata[15:0];
				REG_R0:    cfg_q.r0    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_MODE:  prdata = 32'(cfg_q.mode);
			REG_ALPHA: prdata = 32'(cfg_q.alpha);
			REG_BETA:  prdata = 32'(cfg_q.beta);
			REG_ZCUT:  prdata = 32'(cfg_q.zcut);
			REG_R0:    prdata = 32'(cfg_q.r0);
			default:   prdata = '0;
		endcase
	end

	jsg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.mid_push (mid_push),
		.mid_full (mid_full),
		.mid_word (mid_in)
	);

	jsg_fifo #(.word_t(mid_t), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.wdata  (mid_in),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rdata  (mid_out)
	);

	jsg_back #(.MAX_SPLITS(MAX_SPLITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_word  (mid_out),
		.res_push  (res_push),
		.res_full  (res_full),
		.res_word  (res_word)
	);

	jsg_fifo #(.word_t(out_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_word),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);
endmodule
